/* rtl/tme_pkg.sv */
// Package for the tape machine execute unit: sizes, instruction codes,
// payload structs and the tape write port struct.
// No dependencies.
package tme_pkg;

  // Tape geometry and jump target width.
  localparam int TAPE_CELLS  = 32768;
  localparam int PTR_W       = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
  localparam int TARGET_BITS = 16;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPE_CELLS - 1);
  localparam logic [15:0] TARGET_MASK = 16'((64'd1 << TARGET_BITS) - 64'd1);

  // Instruction codes.
  localparam logic [2:0] FUNC_PTR_LEFT  = 3'd0;
  localparam logic [2:0] FUNC_CELL_DEC  = 3'd1;
  localparam logic [2:0] FUNC_PTR_RIGHT = 3'd2;
  localparam logic [2:0] FUNC_CELL_INC  = 3'd3;
  localparam logic [2:0] FUNC_INPUT     = 3'd4;
  localparam logic [2:0] FUNC_OUTPUT    = 3'd5;
  localparam logic [2:0] FUNC_LOOP_ENT  = 3'd6;
  localparam logic [2:0] FUNC_LOOP_EXIT = 3'd7;

  // One decoded instruction beat.
  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] jump_target;
    logic [7:0]  in_byte;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        branch_taken;
    logic [15:0] branch_address;
  } out_t;

  // Instruction held in the cell stage, with the tape address it read.
  typedef struct packed {
    in_t              instr;
    logic [PTR_W-1:0] addr;
  } stage_t;

  // Tape write request.
  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } wr_t;

endpackage

/* rtl/tape_machine_execute_unit.sv */
// Top level of the tape machine execute unit: cell pointer, tape clearing
// pass, pipeline control and the output register.
// Depends on tme_pkg, tme_ram and tme_cell_stage.

// The unit executes one decoded instruction per cycle, back to back, while
// out_ready is high, and returns exactly one result beat per instruction,
// registered in the cell stage and then in the output register. The rate is
// set by the single read-modify-write of the tape RAM: the cell is read at
// accept, modified and written back when the instruction leaves the cell
// stage, and a forwarding register covers a following instruction that
// reads the same cell. The pointer moves at accept, so pointer moves never
// stall. After reset the unit runs a clearing pass that writes zero to every
// tape cell, one per cycle; in_ready stays low until it is done.
module tape_machine_execute_unit
  import tme_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic             clr_active_r;
  logic [PTR_W-1:0] clr_addr_r;
  logic [PTR_W-1:0] ptr_r;
  logic [PTR_W-1:0] ptr_nxt;
  logic             s1_valid_r;
  stage_t           s1_r;
  logic             out_valid_r;
  out_t             out_r;
  logic             s1_adv;
  logic             in_acc;
  logic [7:0]       rd_data;
  out_t             result;
  wr_t              cell_wr;
  wr_t              ram_wr;

  // Pipeline control.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_acc   = in_valid && in_ready;

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + PTR_W'(1);
      if (clr_addr_r == PTR_LAST) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Pointer update with wraparound at both ends.
  always_comb begin
    ptr_nxt = ptr_r;
    unique case (in_data.func)
      FUNC_PTR_LEFT:  ptr_nxt = (ptr_r == '0) ? PTR_LAST : ptr_r - PTR_W'(1);
      FUNC_PTR_RIGHT: ptr_nxt = (ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (in_acc) begin
      ptr_r <= ptr_nxt;
    end
  end

  // Cell stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.instr <= in_data;
      s1_r.addr  <= ptr_r;
    end
  end

  // Tape write select: the clearing pass owns the port until it ends.
  always_comb begin
    if (clr_active_r) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_addr_r;
      ram_wr.data = 8'd0;
    end else begin
      ram_wr = cell_wr;
    end
  end

  tme_ram #(
    .WIDTH(8),
    .DEPTH(TAPE_CELLS)
  ) u_tape (
    .clk  (clk),
    .we   (ram_wr.en),
    .waddr(ram_wr.addr),
    .wdata(ram_wr.data),
    .re   (in_acc),
    .raddr(ptr_r),
    .rdata(rd_data)
  );

  tme_cell_stage u_cell (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(s1_adv),
    .stage  (s1_r),
    .rd_data(rd_data),
    .result (result),
    .wr     (cell_wr)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_adv || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Nothing enters the pipeline while the tape is being cleared.
  a_no_stage_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_valid_r && !cell_wr.en)
    else $error("cell stage active during clearing pass");

  // The pointer always names a cell of the tape.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_LAST)
    else $error("cell pointer beyond tape");

  // A tape write-back only happens when the instruction leaves the stage.
  a_wr_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cell_wr.en |-> s1_adv)
    else $error("tape write without stage advance");

  // A branch result never comes with an output character.
  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.out_valid && out_r.branch_taken))
    else $error("result carries both output and branch");

endmodule

/* rtl/tme_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; a read at the address being written returns old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tme_cell_stage.sv */
// Cell stage of the tape machine execute unit: merges tape read data with
// the last write, computes the result beat and the tape write-back.
// Depends on tme_pkg.
module tme_cell_stage
  import tme_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  stage_t     stage,
  input  logic [7:0] rd_data,
  output out_t       result,
  output wr_t        wr
);

  logic             fwd_valid_r;
  logic [PTR_W-1:0] fwd_addr_r;
  logic [7:0]       fwd_data_r;
  logic [7:0]       cell_val;
  logic             taken;

  // The most recent tape write is always at least as new as the RAM contents,
  // so it may stand in for the read data whenever the address matches.
  assign cell_val = (fwd_valid_r && (fwd_addr_r == stage.addr)) ? fwd_data_r : rd_data;

  // Result and write-back for the held instruction.
  always_comb begin
    result = '0;
    taken  = 1'b0;
    wr.en   = 1'b0;
    wr.addr = stage.addr;
    wr.data = cell_val;
    unique case (stage.instr.func)
      FUNC_CELL_DEC: begin
        wr.en   = advance;
        wr.data = cell_val - 8'd1;
      end
      FUNC_CELL_INC: begin
        wr.en   = advance;
        wr.data = cell_val + 8'd1;
      end
      FUNC_INPUT: begin
        wr.en   = advance;
        wr.data = stage.instr.in_byte;
      end
      FUNC_OUTPUT: begin
        result.out_valid = 1'b1;
        result.out_byte  = cell_val;
      end
      FUNC_LOOP_ENT:  taken = (cell_val == 8'd0);
      FUNC_LOOP_EXIT: taken = (cell_val != 8'd0);
      default: ;
    endcase
    result.branch_taken   = taken;
    result.branch_address = taken ? (stage.instr.jump_target & TARGET_MASK) : 16'd0;
  end

  // Forwarding register: captures every tape write of this stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (wr.en) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_addr_r <= wr.addr;
      fwd_data_r <= wr.data;
    end
  end

endmodule
